// File: rtl/core/bmpu_pkg.sv
// ----------------------------------------------------------------------------
// bmpu_pkg
// Shared types, register indexes and color tables of the 4bpp bitmap
// pixel unpacker.
// ----------------------------------------------------------------------------
package bmpu_pkg;

    localparam int REG_W   = 10;   // width of the dimension and origin registers
    localparam int POS_W   = 11;   // width of screen coordinates and counters
    localparam int NIB_W   = 4;
    localparam int BYTE_W  = 8;
    localparam int CIDX_W  = 3;    // configuration register index

    typedef logic [CIDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_ORIGIN_X       = 3'd0;
    localparam t_cfg_idx CFG_ORIGIN_Y       = 3'd1;
    localparam t_cfg_idx CFG_IMAGE_WIDTH    = 3'd2;
    localparam t_cfg_idx CFG_IMAGE_HEIGHT   = 3'd3;
    localparam t_cfg_idx CFG_ACTIVE_PALETTE = 3'd4;

    typedef struct packed {
        logic [REG_W-1:0] origin_x;
        logic [REG_W-1:0] origin_y;
        logic [REG_W-1:0] image_width;
        logic [REG_W-1:0] image_height;
        logic             active_palette;
    } t_cfg;

    // Active table swaps the red and blue bits of each color.
    function automatic logic [NIB_W-1:0] pal_active(input logic [NIB_W-1:0] nib);
        logic [NIB_W-1:0] c;
        unique case (nib)
            4'd0:    c = 4'd0;
            4'd1:    c = 4'd4;
            4'd2:    c = 4'd2;
            4'd3:    c = 4'd6;
            4'd4:    c = 4'd1;
            4'd5:    c = 4'd5;
            4'd6:    c = 4'd3;
            4'd7:    c = 4'd7;
            4'd8:    c = 4'd8;
            4'd9:    c = 4'd12;
            4'd10:   c = 4'd10;
            4'd11:   c = 4'd14;
            4'd12:   c = 4'd9;
            4'd13:   c = 4'd13;
            4'd14:   c = 4'd11;
            default: c = 4'd15;
        endcase
        return c;
    endfunction

    // Greyed-out table: colors below 7 go white, color 7 stays 7, bright colors go grey.
    function automatic logic [NIB_W-1:0] pal_grey(input logic [NIB_W-1:0] nib);
        logic [NIB_W-1:0] c;
        if (nib < 4'd7) begin
            c = 4'd15;
        end else if (nib == 4'd7) begin
            c = 4'd7;
        end else begin
            c = 4'd8;
        end
        return c;
    endfunction

    function automatic logic [NIB_W-1:0] remap(input logic active,
                                               input logic [NIB_W-1:0] nib);
        return active ? pal_active(nib) : pal_grey(nib);
    endfunction

endpackage

// File: rtl/core/bmpu_cfg.sv
// ----------------------------------------------------------------------------
// bmpu_cfg
// Configuration register file of the 4bpp bitmap pixel unpacker.
// ----------------------------------------------------------------------------
module bmpu_cfg (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  bmpu_pkg::t_cfg_idx      i_cfg_index,
    input  logic [bmpu_pkg::REG_W-1:0] i_cfg_data,
    output bmpu_pkg::t_cfg          o_cfg
);
    import bmpu_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_x       <= '0;
            r_cfg.origin_y       <= '0;
            r_cfg.image_width    <= '0;
            r_cfg.image_height   <= '0;
            r_cfg.active_palette <= 1'b1;
        end else if (i_cfg_valid) begin
            // Writes to indexes beyond the list are dropped.
            unique case (i_cfg_index)
                CFG_ORIGIN_X:       r_cfg.origin_x       <= i_cfg_data;
                CFG_ORIGIN_Y:       r_cfg.origin_y       <= i_cfg_data;
                CFG_IMAGE_WIDTH:    r_cfg.image_width    <= i_cfg_data;
                CFG_IMAGE_HEIGHT:   r_cfg.image_height   <= i_cfg_data;
                CFG_ACTIVE_PALETTE: r_cfg.active_palette <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

endmodule

// File: rtl/core/bmp_4bpp_nibble_unpacker_core.sv
// ----------------------------------------------------------------------------
// bmp_4bpp_nibble_unpacker_core
// Unpacks 4bpp bitmap bytes into two remapped pixels with screen position.
// ----------------------------------------------------------------------------
// Each accepted byte yields exactly one registered result in the next cycle; a
// new byte is accepted every cycle as long as the result register is empty or
// being drained in the same cycle, so throughput is one byte per clock. The
// column and row counters are updated in the same cycle the byte is taken.
// Rows are walked bottom-up and padded to a multiple of 8 pixels; padding
// pixels come out with their valid flag low, and once all rows are used (or
// width is zero) results carry image_done and no pixels.
// Configuration is written through its own port and is always ready.
module bmp_4bpp_nibble_unpacker_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  bmpu_pkg::t_cfg_idx            i_cfg_index,
    input  logic [bmpu_pkg::REG_W-1:0]    i_cfg_data,
    // byte input
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [bmpu_pkg::BYTE_W-1:0]   i_pixel_byte,
    input  logic                          i_new_image,
    // pixel output
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [bmpu_pkg::POS_W-1:0]    o_pixel_x,
    output logic [bmpu_pkg::POS_W-1:0]    o_pixel_y,
    output logic [bmpu_pkg::NIB_W-1:0]    o_color_first,
    output logic [bmpu_pkg::NIB_W-1:0]    o_color_second,
    output logic                          o_first_valid,
    output logic                          o_second_valid,
    output logic                          o_image_done
);
    import bmpu_pkg::*;

    t_cfg cfg;

    bmpu_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    logic [POS_W-1:0] r_column, n_column;
    logic [POS_W-1:0] r_rows_left, n_rows_left;
    logic             r_out_valid;
    logic [POS_W-1:0] r_pixel_x, n_pixel_x;
    logic [POS_W-1:0] r_pixel_y, n_pixel_y;
    logic [NIB_W-1:0] r_color_first, n_color_first;
    logic [NIB_W-1:0] r_color_second, n_color_second;
    logic             r_first_valid, n_first_valid;
    logic             r_second_valid, n_second_valid;
    logic             r_image_done, n_image_done;

    logic             in_fire;
    logic [POS_W-1:0] col_eff;
    logic [POS_W-1:0] rows_eff;
    logic [POS_W-1:0] col_step;
    logic [POS_W-1:0] width_ext;
    logic [POS_W:0]   col_plus1;
    logic             done;
    logic             row_end;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_fire    = i_in_valid && o_in_ready;

    always_comb begin
        // A restart takes effect before the byte is processed.
        col_eff   = i_new_image ? '0 : r_column;
        rows_eff  = i_new_image ? {1'b0, cfg.image_height} : r_rows_left;
        width_ext = {1'b0, cfg.image_width};
        done      = (rows_eff == '0) || (cfg.image_width == '0);
        col_step  = col_eff + POS_W'(2);
        col_plus1 = {1'b0, col_eff} + (POS_W+1)'(1);
        row_end   = (col_step[2:0] == 3'd0) && (col_step >= width_ext);

        n_pixel_x      = '0;
        n_pixel_y      = '0;
        n_color_first  = '0;
        n_color_second = '0;
        n_first_valid  = 1'b0;
        n_second_valid = 1'b0;
        n_image_done   = done;
        n_column       = col_eff;
        n_rows_left    = rows_eff;

        if (!done) begin
            n_pixel_x      = POS_W'({1'b0, cfg.origin_x} + col_eff);
            n_pixel_y      = POS_W'({1'b0, cfg.origin_y} + rows_eff);
            n_color_first  = remap(cfg.active_palette, i_pixel_byte[7:4]);
            n_color_second = remap(cfg.active_palette, i_pixel_byte[3:0]);
            n_first_valid  = col_eff < width_ext;
            n_second_valid = col_plus1 < {1'b0, width_ext};
            if (row_end) begin
                n_column    = '0;
                n_rows_left = rows_eff - POS_W'(1);
            end else begin
                n_column    = col_step;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column    <= '0;
            r_rows_left <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_column    <= n_column;
                r_rows_left <= n_rows_left;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_pixel_x      <= n_pixel_x;
            r_pixel_y      <= n_pixel_y;
            r_color_first  <= n_color_first;
            r_color_second <= n_color_second;
            r_first_valid  <= n_first_valid;
            r_second_valid <= n_second_valid;
            r_image_done   <= n_image_done;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_pixel_x      = r_pixel_x;
    assign o_pixel_y      = r_pixel_y;
    assign o_color_first  = r_color_first;
    assign o_color_second = r_color_second;
    assign o_first_valid  = r_first_valid;
    assign o_second_valid = r_second_valid;
    assign o_image_done   = r_image_done;

    // The column always advances by a whole byte, so it stays even.
    a_column_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_column[0] == 1'b0)
        else $error("column counter became odd");

    // A second pixel inside the image implies the first one is too.
    a_second_implies_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_second_valid) |-> o_first_valid)
        else $error("second pixel valid without first");

    // Finished images produce no pixels.
    a_done_no_pixels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_image_done) |-> (!o_first_valid && !o_second_valid))
        else $error("pixel flagged valid after image done");

    // A restart with a nonempty image always produces a live result.
    a_restart_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_new_image && cfg.image_height != '0 && cfg.image_width != '0)
        |=> (o_out_valid && !o_image_done))
        else $error("restart of nonempty image reported done");

endmodule
